// ===== rtl/core/hsmg_pkg.sv =====
// shared types and constants for the h-bot smooth move generator
// no dependencies
package hsmg_pkg;

  localparam int unsigned MAX_STEPS = 32;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned CNT_W     = STEP_W + 1;
  localparam int unsigned DIV_STEPS = 24;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);
  localparam logic [24:0] ONE_Q24   = 25'h1000000;
  localparam logic [29:0] TEN_Q24   = 30'd167772160;
  localparam logic [CNT_W-1:0] MAX_STEPS_C = CNT_W'(MAX_STEPS);

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_TICKS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS  = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIFF,
    ST_EMIT,
    ST_WAIT
  } state_e;

  typedef enum logic [2:0] {
    MS_U2,
    MS_U3,
    MS_S,
    MS_PX,
    MS_PY,
    MS_RA,
    MS_RB
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     next_step;
    logic     set_s_zero;
    logic     set_s_one;
    logic     div_init;
    logic     div_step;
    logic     mul_lo;
    logic     mul_hi;
    mul_sel_e sel;
    logic     diff;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic ticks_zero;
    logic k_ge_ticks;
    logic last;
  } status_t;

endpackage

// ===== rtl/core/hsmg_ctrl.sv =====
// sequencer for the smooth move generator: divide, multiply steps, emit
// depends on hsmg_pkg
module hsmg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  hsmg_pkg::status_t      status_i,
  output hsmg_pkg::cmd_t         cmd_o
);

  hsmg_pkg::state_e               state_q, state_d;
  hsmg_pkg::mul_sel_e             sel_q, sel_d;
  logic [hsmg_pkg::DCNT_W-1:0]    dcnt_q, dcnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsmg_pkg::ST_IDLE;
      sel_q   <= hsmg_pkg::MS_U2;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    dcnt_d      = dcnt_q;
    cmd_o       = '0;
    cmd_o.sel   = sel_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      hsmg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = hsmg_pkg::ST_WAIT;
        end
      end
      hsmg_pkg::ST_START: begin
        if (status_i.ticks_zero) begin
          cmd_o.set_s_zero = 1'b1;
          sel_d            = hsmg_pkg::MS_PX;
          state_d          = hsmg_pkg::ST_MUL_LO;
        end else if (status_i.k_ge_ticks) begin
          cmd_o.set_s_one = 1'b1;
          sel_d           = hsmg_pkg::MS_PX;
          state_d         = hsmg_pkg::ST_MUL_LO;
        end else begin
          cmd_o.div_init = 1'b1;
          dcnt_d         = '0;
          state_d        = hsmg_pkg::ST_DIV;
        end
      end
      hsmg_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 1'b1;
        if (dcnt_q == hsmg_pkg::DCNT_W'(hsmg_pkg::DIV_STEPS - 1)) begin
          sel_d   = hsmg_pkg::MS_U2;
          state_d = hsmg_pkg::ST_MUL_LO;
        end
      end
      hsmg_pkg::ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = hsmg_pkg::ST_MUL_HI;
      end
      hsmg_pkg::ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        unique case (sel_q)
          hsmg_pkg::MS_PY: state_d = hsmg_pkg::ST_DIFF;
          hsmg_pkg::MS_RB: state_d = hsmg_pkg::ST_EMIT;
          default: begin
            sel_d   = hsmg_pkg::mul_sel_e'(sel_q + 3'd1);
            state_d = hsmg_pkg::ST_MUL_LO;
          end
        endcase
      end
      hsmg_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        sel_d      = hsmg_pkg::MS_RA;
        state_d    = hsmg_pkg::ST_MUL_LO;
      end
      hsmg_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d    = hsmg_pkg::ST_WAIT;
      end
      hsmg_pkg::ST_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) begin
            state_d = hsmg_pkg::ST_IDLE;
          end else begin
            cmd_o.next_step = 1'b1;
            state_d         = hsmg_pkg::ST_START;
          end
        end
      end
      default: state_d = hsmg_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/hsmg_dp.sv =====
// datapath: config registers, restoring divider, shared 34x16 multiplier, output word
// depends on hsmg_pkg
module hsmg_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hsmg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                       cfg_wdata_i,
  input  logic [31:0]                       target_x_i,
  input  logic [31:0]                       target_y_i,
  input  hsmg_pkg::cmd_t                    cmd_i,
  output hsmg_pkg::status_t                 status_o,
  output logic [hsmg_pkg::STEP_W-1:0]       step_index_o,
  output logic [31:0]                       rot_a_o,
  output logic [31:0]                       rot_b_o,
  output logic                              last_o
);

  logic [15:0] ticks_q;
  logic [31:0] inv_q;
  logic [31:0] tx_q, ty_q, prevx_q, prevy_q, posx_q, posy_q;
  logic [hsmg_pkg::STEP_W-1:0] k_q;
  logic [15:0] rem_q;
  logic [23:0] u_q, u2_q, u3_q;
  logic [24:0] s_q;
  logic [33:0] ma_q, mb_q;
  logic        na_q, nb_q;
  logic [65:0] acc_q;
  logic [31:0] ra_q, rb_q;
  logic [hsmg_pkg::STEP_W-1:0] oidx_q;
  logic [31:0] ora_q, orb_q;
  logic        olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= 16'd10;
      inv_q   <= 32'h0100_0000;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == hsmg_pkg::CFG_TOTAL_TICKS) ticks_q <= cfg_wdata_i[15:0];
      else if (cfg_idx_i == hsmg_pkg::CFG_INV_RADIUS) inv_q <= cfg_wdata_i;
    end
  end

  // divider step
  logic [16:0] rem_sh;
  logic        rem_ge;
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, ticks_q};

  // quintic weight, never negative for u < 1
  logic [29:0] w_full;
  logic [31:0] w_op;
  assign w_full = hsmg_pkg::TEN_Q24 - 30'(u_q) * 30'd15 + 30'(u2_q) * 30'd6;
  assign w_op   = w_full[29] ? 32'd0 : {4'd0, w_full[27:0]};

  logic [31:0] absx, absy;
  assign absx = tx_q[31] ? 32'(-tx_q) : tx_q;
  assign absy = ty_q[31] ? 32'(-ty_q) : ty_q;

  logic [33:0] op_a;
  logic [31:0] op_b;
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.sel)
      hsmg_pkg::MS_U2: begin op_a = 34'(u_q);  op_b = 32'(u_q); end
      hsmg_pkg::MS_U3: begin op_a = 34'(u2_q); op_b = 32'(u_q); end
      hsmg_pkg::MS_S:  begin op_a = 34'(u3_q); op_b = w_op;     end
      hsmg_pkg::MS_PX: begin op_a = 34'(absx); op_b = 32'(s_q); end
      hsmg_pkg::MS_PY: begin op_a = 34'(absy); op_b = 32'(s_q); end
      hsmg_pkg::MS_RA: begin op_a = ma_q;      op_b = inv_q;    end
      hsmg_pkg::MS_RB: begin op_a = mb_q;      op_b = inv_q;    end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  logic [49:0] pp;
  logic [65:0] res;
  logic [41:0] rsh;
  assign pp  = op_a * (cmd_i.mul_hi ? op_b[31:16] : op_b[15:0]);
  assign res = acc_q + {pp, 16'd0};
  assign rsh = res[65:24];

  logic [31:0] sat_r;
  logic        sat_neg;
  assign sat_neg = (cmd_i.sel == hsmg_pkg::MS_RA) ? na_q : nb_q;
  always_comb begin
    if (sat_neg) begin
      sat_r = (rsh >= 42'h0_8000_0000) ? 32'h8000_0000 : 32'(-rsh[31:0]);
    end else begin
      sat_r = (rsh > 42'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rsh[31:0];
    end
  end

  logic [33:0] dx, dy, da, db;
  assign dx = 34'($signed(posx_q)) - 34'($signed(prevx_q));
  assign dy = 34'($signed(posy_q)) - 34'($signed(prevy_q));
  assign da = dy - dx;
  assign db = 34'(-(dy + dx));

  logic [hsmg_pkg::CNT_W-1:0] n_next;
  assign n_next = hsmg_pkg::CNT_W'(k_q) + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tx_q    <= target_x_i;
      ty_q    <= target_y_i;
      prevx_q <= '0;
      prevy_q <= '0;
      k_q     <= '0;
      oidx_q  <= '0;
      ora_q   <= '0;
      orb_q   <= '0;
      olast_q <= (hsmg_pkg::MAX_STEPS_C <= 1);
    end
    if (cmd_i.next_step) k_q <= k_q + 1'b1;
    if (cmd_i.set_s_zero) s_q <= '0;
    if (cmd_i.set_s_one)  s_q <= hsmg_pkg::ONE_Q24;
    if (cmd_i.div_init) begin
      rem_q <= 16'(k_q);
      u_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? 16'(rem_sh - {1'b0, ticks_q}) : rem_sh[15:0];
      u_q   <= {u_q[22:0], rem_ge};
    end
    if (cmd_i.mul_lo) acc_q <= 66'(pp);
    if (cmd_i.mul_hi) begin
      case (cmd_i.sel)
        hsmg_pkg::MS_U2: u2_q <= rsh[23:0];
        hsmg_pkg::MS_U3: u3_q <= rsh[23:0];
        hsmg_pkg::MS_S:  s_q  <= (rsh > 42'(hsmg_pkg::ONE_Q24)) ? hsmg_pkg::ONE_Q24 : rsh[24:0];
        hsmg_pkg::MS_PX: posx_q <= tx_q[31] ? 32'(-rsh[31:0]) : rsh[31:0];
        hsmg_pkg::MS_PY: posy_q <= ty_q[31] ? 32'(-rsh[31:0]) : rsh[31:0];
        hsmg_pkg::MS_RA: ra_q <= sat_r;
        hsmg_pkg::MS_RB: rb_q <= sat_r;
        default: ;
      endcase
    end
    if (cmd_i.diff) begin
      na_q <= da[33];
      nb_q <= db[33];
      ma_q <= da[33] ? 34'(-da) : da;
      mb_q <= db[33] ? 34'(-db) : db;
    end
    if (cmd_i.emit) begin
      oidx_q  <= k_q;
      ora_q   <= ra_q;
      orb_q   <= rb_q;
      olast_q <= (s_q == hsmg_pkg::ONE_Q24) || (n_next >= hsmg_pkg::MAX_STEPS_C);
      prevx_q <= posx_q;
      prevy_q <= posy_q;
    end
  end

  assign status_o.ticks_zero = (ticks_q == 16'd0);
  assign status_o.k_ge_ticks = (16'(k_q) >= ticks_q);
  assign status_o.last       = olast_q;

  assign step_index_o = oidx_q;
  assign rot_a_o      = ora_q;
  assign rot_b_o      = orb_q;
  assign last_o       = olast_q;

endmodule

// ===== rtl/core/hbot_smooth_move_generator_unit.sv =====
// Smooth move generator for an h-bot stage. Each input word is a move target
// (x, y, signed Q16.16); the block answers with a run of pulley rotation
// pairs following a quintic minimum-jerk profile, starting with a zero pair
// and ending (tlast) when the profile reaches 1.0 or after 32 pairs. Each
// pair after the first needs the bit-serial divide u = k/total_ticks
// (skipped once k reaches total_ticks, or when total_ticks is zero) and
// seven products on the shared 34x16 multiplier (four without the divide),
// each as two 16-bit halves; a new move waits until the last pair has left.
// depends on hsmg_pkg, hsmg_ctrl, hsmg_dp
module hbot_smooth_move_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // target_x, target_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // step_index, rot_a, rot_b, zero pad
  output logic        m_axis_tlast
);

  hsmg_pkg::cmd_t    cmd;
  hsmg_pkg::status_t status;
  logic [hsmg_pkg::STEP_W-1:0] step_index;
  logic [31:0] rot_a, rot_b;

  hsmg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hsmg_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .target_x_i   (s_axis_tdata[31:0]),
    .target_y_i   (s_axis_tdata[63:32]),
    .cmd_i        (cmd),
    .status_o     (status),
    .step_index_o (step_index),
    .rot_a_o      (rot_a),
    .rot_b_o      (rot_b),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, rot_b, rot_a, step_index};

endmodule
